// ===== rtl/core/mnab_pkg.sv =====
// ----------------------------------------------------------------------------
// mnab_pkg
// Shared widths, defaults and codes for the mesh node adjacency builder.
// ----------------------------------------------------------------------------
`default_nettype none

package mnab_pkg;

  localparam int GRID_MAX_DEF  = 64;
  localparam int MAX_SLOTS_DEF = 8;

  localparam int ID_W      = 12;
  localparam int COL_W     = 6;
  localparam int SLOT_W    = 3;
  localparam int CNT_OUT_W = 4;
  localparam int DIM_RAW_W = 7;
  localparam int DIM_RESET = 64;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_GRID_COLUMNS = 1'b0,
    REG_GRID_ROWS    = 1'b1
  } reg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/core/mesh_node_adjacency_builder.sv =====
// ----------------------------------------------------------------------------
// mesh_node_adjacency_builder
// Per-node neighbor lists of a triangulated grid, held in a count memory
// and a slot memory, updated by read-modify-write one link at a time.
// Read transaction: request check, count and slot read, then the result.
// Add transaction: 12 link updates, each reading the list count, scanning
// its slots and appending the neighbor if it is absent and the list is not
// full; the result then reports the list count of the first corner.
// Out-of-range request: answered with an error result.
// One transaction in flight; the sequencer and its memory ports set the pace.
// After reset every count memory entry is set to one, with in_stall high;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_node_adjacency_builder #(
  parameter int GRID_MAX  = mnab_pkg::GRID_MAX_DEF,
  parameter int MAX_SLOTS = mnab_pkg::MAX_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mnab_pkg::CFG_AW-1:0]    paddr,
  input  logic [mnab_pkg::CFG_DW-1:0]    pwdata,
  output logic [mnab_pkg::CFG_DW-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [mnab_pkg::COL_W-1:0]     in_cell_col,
  input  logic [mnab_pkg::COL_W-1:0]     in_cell_row,
  input  logic [mnab_pkg::ID_W-1:0]      in_node_index,
  input  logic [mnab_pkg::SLOT_W-1:0]    in_slot_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mnab_pkg::ID_W-1:0]      out_neighbor_id,
  output logic [mnab_pkg::CNT_OUT_W-1:0] out_list_count,
  output logic                           out_list_full,
  output logic                           out_request_error
);

  import mnab_pkg::*;

  localparam int NODE_TOTAL = GRID_MAX * GRID_MAX;
  localparam int NODE_W = $clog2(NODE_TOTAL);
  localparam int TAB_AW = $clog2(NODE_TOTAL * MAX_SLOTS);
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int DIM_W  = $clog2(GRID_MAX + 1);
  localparam int AREA_W = $clog2(NODE_TOTAL + 1);

  logic [DIM_W-1:0]  cols;
  logic [DIM_W-1:0]  rows;
  logic [AREA_W-1:0] area;

  logic              cnt_we;
  logic [NODE_W-1:0] cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [NODE_W-1:0] cnt_raddr;
  logic [CNT_W-1:0]  cnt_rdata;

  logic              tab_we;
  logic [TAB_AW-1:0] tab_waddr;
  logic [ID_W-1:0]   tab_wdata;
  logic [TAB_AW-1:0] tab_raddr;
  logic [ID_W-1:0]   tab_rdata;

  mnab_cfg #(
    .GRID_MAX (GRID_MAX)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cols    (cols),
    .rows    (rows),
    .area    (area)
  );

  mnab_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NODE_TOTAL)
  ) u_cnt_mem (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  mnab_ram #(
    .WIDTH (ID_W),
    .DEPTH (NODE_TOTAL * MAX_SLOTS)
  ) u_tab_mem (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  mnab_ctrl #(
    .GRID_MAX  (GRID_MAX),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cols              (cols),
    .rows              (rows),
    .area              (area),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_cell_col       (in_cell_col),
    .in_cell_row       (in_cell_row),
    .in_node_index     (in_node_index),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_neighbor_id   (out_neighbor_id),
    .out_list_count    (out_list_count),
    .out_list_full     (out_list_full),
    .out_request_error (out_request_error),
    .cnt_we            (cnt_we),
    .cnt_waddr         (cnt_waddr),
    .cnt_wdata         (cnt_wdata),
    .cnt_raddr         (cnt_raddr),
    .cnt_rdata         (cnt_rdata),
    .tab_we            (tab_we),
    .tab_waddr         (tab_waddr),
    .tab_wdata         (tab_wdata),
    .tab_raddr         (tab_raddr),
    .tab_rdata         (tab_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/mnab_ram.sv =====
// ----------------------------------------------------------------------------
// mnab_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mnab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mnab_cfg.sv =====
// ----------------------------------------------------------------------------
// mnab_cfg
// APB register file for grid dimensions; clamps them and registers the
// node count of the grid.
// ----------------------------------------------------------------------------
`default_nettype none

module mnab_cfg #(
  parameter int GRID_MAX = mnab_pkg::GRID_MAX_DEF,
  localparam int NODE_TOTAL = GRID_MAX * GRID_MAX,
  localparam int DIM_W  = $clog2(GRID_MAX + 1),
  localparam int AREA_W = $clog2(NODE_TOTAL + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mnab_pkg::CFG_AW-1:0] paddr,
  input  logic [mnab_pkg::CFG_DW-1:0] pwdata,
  output logic [mnab_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output logic [DIM_W-1:0]            cols,
  output logic [DIM_W-1:0]            rows,
  output logic [AREA_W-1:0]           area
);

  import mnab_pkg::*;

  localparam int DIM_RST = (DIM_RESET > GRID_MAX) ? GRID_MAX : DIM_RESET;

  logic [DIM_RAW_W-1:0] cols_raw_r;
  logic [DIM_RAW_W-1:0] rows_raw_r;
  logic [AREA_W-1:0]    area_r;
  logic                 wr_en;
  reg_idx_t             reg_idx;

  function automatic int clamp_dim(input logic [DIM_RAW_W-1:0] v);
    int t;
    t = int'(v);
    if (t < 2) begin
      t = 2;
    end else if (t > GRID_MAX) begin
      t = GRID_MAX;
    end
    return t;
  endfunction

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_raw_r <= DIM_RAW_W'(DIM_RESET);
      rows_raw_r <= DIM_RAW_W'(DIM_RESET);
      area_r     <= AREA_W'(DIM_RST * DIM_RST);
    end else begin
      if (wr_en) begin
        case (reg_idx)
          REG_GRID_COLUMNS: cols_raw_r <= pwdata[DIM_RAW_W-1:0];
          REG_GRID_ROWS:    rows_raw_r <= pwdata[DIM_RAW_W-1:0];
          default:          ;
        endcase
      end
      area_r <= AREA_W'(cols) * AREA_W'(rows);
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRID_COLUMNS: prdata = CFG_DW'(cols_raw_r);
      REG_GRID_ROWS:    prdata = CFG_DW'(rows_raw_r);
      default:          prdata = '0;
    endcase
  end

  assign cols = DIM_W'(clamp_dim(cols_raw_r));
  assign rows = DIM_W'(clamp_dim(rows_raw_r));
  assign area = area_r;

endmodule

`default_nettype wire

// ===== rtl/core/mnab_ctrl.sv =====
// ----------------------------------------------------------------------------
// mnab_ctrl
// Sequencer: count memory init after reset, request checks, the twelve
// link updates of an add (read count, scan slots, append), slot reads,
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mnab_ctrl #(
  parameter int GRID_MAX  = mnab_pkg::GRID_MAX_DEF,
  parameter int MAX_SLOTS = mnab_pkg::MAX_SLOTS_DEF,
  localparam int NODE_TOTAL = GRID_MAX * GRID_MAX,
  localparam int NODE_W = $clog2(NODE_TOTAL),
  localparam int TAB_AW = $clog2(NODE_TOTAL * MAX_SLOTS),
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1),
  localparam int DIM_W  = $clog2(GRID_MAX + 1),
  localparam int AREA_W = $clog2(NODE_TOTAL + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [DIM_W-1:0]               cols,
  input  logic [DIM_W-1:0]               rows,
  input  logic [AREA_W-1:0]              area,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [mnab_pkg::COL_W-1:0]     in_cell_col,
  input  logic [mnab_pkg::COL_W-1:0]     in_cell_row,
  input  logic [mnab_pkg::ID_W-1:0]      in_node_index,
  input  logic [mnab_pkg::SLOT_W-1:0]    in_slot_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mnab_pkg::ID_W-1:0]      out_neighbor_id,
  output logic [mnab_pkg::CNT_OUT_W-1:0] out_list_count,
  output logic                           out_list_full,
  output logic                           out_request_error,
  output logic                           cnt_we,
  output logic [NODE_W-1:0]              cnt_waddr,
  output logic [CNT_W-1:0]               cnt_wdata,
  output logic [NODE_W-1:0]              cnt_raddr,
  input  logic [CNT_W-1:0]               cnt_rdata,
  output logic                           tab_we,
  output logic [TAB_AW-1:0]              tab_waddr,
  output logic [mnab_pkg::ID_W-1:0]      tab_wdata,
  output logic [TAB_AW-1:0]              tab_raddr,
  input  logic [mnab_pkg::ID_W-1:0]      tab_rdata
);

  import mnab_pkg::*;

  localparam int PROD_W = (COL_W + DIM_W + 1 > NODE_W) ? COL_W + DIM_W + 1 : NODE_W;
  localparam int CW     = (COL_W > DIM_W) ? COL_W + 1 : DIM_W + 1;
  localparam int RW     = (ID_W > AREA_W) ? ID_W : AREA_W;
  localparam int CMP_W  = (ID_W > NODE_W) ? ID_W : NODE_W;
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(11);

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_CHECK  = 10'b0000000100,
    ST_CORNER = 10'b0000001000,
    ST_SETUP  = 10'b0000010000,
    ST_COUNT  = 10'b0000100000,
    ST_SCAN   = 10'b0001000000,
    ST_FINAL  = 10'b0010000000,
    ST_RDATA  = 10'b0100000000,
    ST_RESP   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  cmd_t               cmd_r;
  logic [COL_W-1:0]   col_r;
  logic [COL_W-1:0]   row_r;
  logic [ID_W-1:0]    node_r;
  logic [SLOT_W-1:0]  slot_r;

  logic [NODE_W-1:0]  a_r, b_r, c_r, d_r;
  logic [NODE_W-1:0]  n_r, nb_r;
  logic [NODE_W-1:0]  sel_n, sel_nb;
  logic [NODE_W-1:0]  clr_r;
  logic [NODE_W-1:0]  rd_node;
  logic [TAB_AW-1:0]  base_r;
  logic [TAB_AW-1:0]  rd_addr;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   s_r;
  logic [STEP_W-1:0]  step_r;
  logic               found_r;
  logic               pend_r;
  logic               full_r;

  logic [ID_W-1:0]      res_id_r;
  logic [CNT_OUT_W-1:0] res_cnt_r;
  logic                 res_full_r;
  logic                 res_err_r;

  logic                 out_valid_r;
  logic [ID_W-1:0]      out_id_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic                 out_full_r;
  logic                 out_err_r;

  logic [PROD_W-1:0]  a_full;
  logic               add_bad;
  logic               read_bad;
  logic               in_take;
  logic               out_free;
  logic               hit_now;
  logic               issue;
  logic               scan_done;
  logic               append;
  logic [ID_W-1:0]    rd_id;

  assign in_take  = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign a_full   = PROD_W'(col_r) * PROD_W'(rows) + PROD_W'(row_r);
  assign add_bad  = ((CW'(col_r) + CW'(1)) >= CW'(cols)) ||
                    ((CW'(row_r) + CW'(1)) >= CW'(rows));
  assign read_bad = (RW'(node_r) >= RW'(area)) ||
                    (CNT_W'(slot_r) >= CNT_W'(MAX_SLOTS));

  assign rd_node  = NODE_W'(node_r);
  assign rd_addr  = TAB_AW'(rd_node) * TAB_AW'(MAX_SLOTS) + TAB_AW'(slot_r);

  assign hit_now   = pend_r && (CMP_W'(tab_rdata) == CMP_W'(nb_r));
  assign issue     = (state_r == ST_SCAN) && !found_r && (s_r < cnt_r);
  assign scan_done = (state_r == ST_SCAN) && !pend_r && (found_r || (s_r >= cnt_r));
  assign append    = scan_done && !found_r && (cnt_r < CNT_W'(MAX_SLOTS));

  // slot zero always holds the node itself
  assign rd_id = (slot_r == '0) ? node_r :
                 ((CNT_W'(slot_r) < cnt_rdata) ? tab_rdata : '0);

  // link order: each corner of (a,b,c) then of (a,c,d) gets the other two
  always_comb begin
    case (step_r)
      4'd0:    begin sel_n = a_r; sel_nb = b_r; end
      4'd1:    begin sel_n = a_r; sel_nb = c_r; end
      4'd2:    begin sel_n = b_r; sel_nb = c_r; end
      4'd3:    begin sel_n = b_r; sel_nb = a_r; end
      4'd4:    begin sel_n = c_r; sel_nb = a_r; end
      4'd5:    begin sel_n = c_r; sel_nb = b_r; end
      4'd6:    begin sel_n = a_r; sel_nb = c_r; end
      4'd7:    begin sel_n = a_r; sel_nb = d_r; end
      4'd8:    begin sel_n = c_r; sel_nb = d_r; end
      4'd9:    begin sel_n = c_r; sel_nb = a_r; end
      4'd10:   begin sel_n = d_r; sel_nb = a_r; end
      4'd11:   begin sel_n = d_r; sel_nb = c_r; end
      default: begin sel_n = a_r; sel_nb = b_r; end
    endcase
  end

  assign cnt_we    = (state_r == ST_CLEAR) || append;
  assign cnt_waddr = (state_r == ST_CLEAR) ? clr_r : n_r;
  assign cnt_wdata = (state_r == ST_CLEAR) ? CNT_W'(1) : cnt_r + CNT_W'(1);

  always_comb begin
    case (state_r)
      ST_SETUP: cnt_raddr = sel_n;
      ST_FINAL: cnt_raddr = a_r;
      default:  cnt_raddr = rd_node;
    endcase
  end

  assign tab_we    = append;
  assign tab_waddr = base_r + TAB_AW'(cnt_r);
  assign tab_wdata = ID_W'(nb_r);
  assign tab_raddr = (state_r == ST_SCAN) ? base_r + TAB_AW'(s_r) : rd_addr;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == NODE_W'(NODE_TOTAL - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (cmd_r == CMD_ADD) begin
          state_nxt = add_bad ? ST_RESP : ST_CORNER;
        end else begin
          state_nxt = read_bad ? ST_RESP : ST_RDATA;
        end
      end
      ST_CORNER: state_nxt = ST_SETUP;
      ST_SETUP:  state_nxt = ST_COUNT;
      ST_COUNT:  state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = (step_r == LAST_STEP) ? ST_FINAL : ST_SETUP;
        end
      end
      ST_FINAL: state_nxt = ST_RDATA;
      ST_RDATA: state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      step_r      <= '0;
      s_r         <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + NODE_W'(1);
      end
      if (in_take) begin
        full_r <= 1'b0;
      end
      if (state_r == ST_CORNER) begin
        step_r <= '0;
      end
      if (state_r == ST_COUNT) begin
        s_r     <= CNT_W'(1);
        pend_r  <= 1'b0;
        found_r <= (CMP_W'(ID_W'(n_r)) == CMP_W'(nb_r));
      end
      if (state_r == ST_SCAN) begin
        pend_r <= issue;
        if (issue) begin
          s_r <= s_r + CNT_W'(1);
        end
        if (hit_now) begin
          found_r <= 1'b1;
        end
        if (scan_done) begin
          step_r <= step_r + STEP_W'(1);
          if (!found_r && !append) begin
            full_r <= 1'b1;
          end
        end
      end
      if ((state_r == ST_RESP) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r  <= cmd_t'(in_command);
      col_r  <= in_cell_col;
      row_r  <= in_cell_row;
      node_r <= in_node_index;
      slot_r <= in_slot_index;
    end
    if (state_r == ST_CHECK) begin
      a_r        <= a_full[NODE_W-1:0];
      res_id_r   <= '0;
      res_cnt_r  <= '0;
      res_full_r <= 1'b0;
      res_err_r  <= 1'b1;
    end
    if (state_r == ST_CORNER) begin
      b_r <= a_r + NODE_W'(rows);
      c_r <= a_r + NODE_W'(rows) + NODE_W'(1);
      d_r <= a_r + NODE_W'(1);
    end
    if (state_r == ST_SETUP) begin
      n_r  <= sel_n;
      nb_r <= sel_nb;
    end
    if (state_r == ST_COUNT) begin
      cnt_r  <= cnt_rdata;
      base_r <= TAB_AW'(n_r) * TAB_AW'(MAX_SLOTS);
    end
    if (state_r == ST_RDATA) begin
      res_err_r <= 1'b0;
      res_cnt_r <= CNT_OUT_W'(cnt_rdata);
      if (cmd_r == CMD_ADD) begin
        res_id_r   <= '0;
        res_full_r <= full_r;
      end else begin
        res_id_r   <= rd_id;
        res_full_r <= 1'b0;
      end
    end
    if ((state_r == ST_RESP) && out_free) begin
      out_id_r   <= res_id_r;
      out_cnt_r  <= res_cnt_r;
      out_full_r <= res_full_r;
      out_err_r  <= res_err_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_neighbor_id   = out_id_r;
  assign out_list_count    = out_cnt_r;
  assign out_list_full     = out_full_r;
  assign out_request_error = out_err_r;

endmodule

`default_nettype wire
